/* rtl/ttb_pkg.sv */
// Shared types and constants for the travelled trail buffer.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package ttb_pkg;

   localparam int TRAIL_DEPTH_DEFAULT = 64;
   localparam int COORD_W             = 24;
   localparam int SQ_W                = 2 * COORD_W;
   localparam int DIST_W              = SQ_W + 1;

   // Configuration register indexes
   localparam logic CSR_RESOLUTION   = 1'b0;
   localparam logic CSR_RESET_RADIUS = 1'b1;

   typedef enum logic [1:0] {
      STAT_UPDATED   = 2'd0,
      STAT_UNCHANGED = 2'd1,
      STAT_NO_POSE   = 2'd2
   } status_type;

   // What a transaction in the distance pipeline computes
   typedef enum logic [2:0] {
      KIND_RES,
      KIND_RAD,
      KIND_MAX,
      KIND_LAST,
      KIND_SCAN,
      KIND_PRUNE,
      KIND_EMIT
   } kind_type;

   typedef enum logic [4:0] {
      ST_IDLE,
      ST_CHECK,
      ST_PRE_RES,
      ST_PRE_RAD,
      ST_PRE_MAX,
      ST_PRE_LAST,
      ST_PRE_WAIT,
      ST_DECIDE,
      ST_SCAN,
      ST_SCAN_WAIT,
      ST_TRUNC,
      ST_APPEND,
      ST_PRUNE,
      ST_PRUNE_WAIT,
      ST_PRUNE_APPLY,
      ST_EMIT,
      ST_EMIT_WAIT
   } state_type;

   typedef struct packed {
      logic       load;
      logic       iss_valid;
      kind_type   iss_kind;
      logic       cnt_clear;
      logic       cnt_inc;
      logic       scan_init;
      logic       truncate;
      logic       append;
      logic       restart;
      logic       prune_init;
      logic       prune_apply;
      logic       single;
      status_type single_status;
   } ctl_cmd_type;

   typedef struct packed {
      logic pose_valid;
      logic len_zero;
      logic len_ge2;
      logic maxd_zero;
      logic below_res;
      logic within_rad;
      logic cnt_scan_end;
      logic cnt_last;
      logic pipe_busy;
   } dp_stat_type;

endpackage

/* rtl/travelled_trail_buffer.sv */
// Top level of the travelled trail buffer: sequencer plus datapath.
// Depends on ttb_pkg, ttb_ctrl and ttb_datapath.
`timescale 1ns / 1ps

// A transaction is taken when start is high and busy is low; busy stays high
// until every result of that transaction has been issued. Results come out on
// the rsp_ ports one per cycle with rsp_strobe and cannot be held off, so the
// receiver must take each one in the cycle it appears; a trail update streams
// its points oldest first in back-to-back cycles with rsp_last on the newest.
// The longest transaction scans, prunes and emits the trail; shorter ones end when
// the move is under the resolution or reset mode keeps the trail, and the
// shortest when the pose is unavailable. The long case is set by the single
// read port of the trail memory, which is swept three times, plus the fill and
// drain of the four-stage distance pipeline (read, difference, square, sum)
// around each sweep. Configuration writes are taken at any edge, but are meant
// for idle.

module travelled_trail_buffer import ttb_pkg::*; #(
   parameter int TRAIL_DEPTH = TRAIL_DEPTH_DEFAULT,
   localparam int CNT_W = $clog2(TRAIL_DEPTH + 1)
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      start,
   output logic                      busy,
   input  logic signed [COORD_W-1:0] req_pos_x,
   input  logic signed [COORD_W-1:0] req_pos_y,
   input  logic                      req_pose_valid,
   input  logic [COORD_W-1:0]        req_max_distance_mm,
   input  logic                      csr_write_en,
   input  logic                      csr_index,
   input  logic [COORD_W-1:0]        csr_wdata,
   output logic                      rsp_strobe,
   output logic [1:0]                rsp_status,
   output logic signed [COORD_W-1:0] rsp_point_x,
   output logic signed [COORD_W-1:0] rsp_point_y,
   output logic [CNT_W-1:0]          rsp_point_count,
   output logic                      rsp_last
);

   ctl_cmd_type cmd;
   dp_stat_type stat;

   // Sequencer: owns the step order, holds nothing of the trail itself
   ttb_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .start (start),
      .busy  (busy),
      .stat  (stat),
      .cmd   (cmd)
   );

   // Datapath: trail ring, distance pipeline and result registers
   ttb_datapath #(
      .TRAIL_DEPTH (TRAIL_DEPTH)
   ) u_dp (
      .clock               (clock),
      .reset               (reset),
      .cmd                 (cmd),
      .stat                (stat),
      .req_pos_x           (req_pos_x),
      .req_pos_y           (req_pos_y),
      .req_pose_valid      (req_pose_valid),
      .req_max_distance_mm (req_max_distance_mm),
      .csr_write_en        (csr_write_en),
      .csr_index           (csr_index),
      .csr_wdata           (csr_wdata),
      .rsp_strobe          (rsp_strobe),
      .rsp_status          (rsp_status),
      .rsp_point_x         (rsp_point_x),
      .rsp_point_y         (rsp_point_y),
      .rsp_point_count     (rsp_point_count),
      .rsp_last            (rsp_last)
   );

endmodule

/* rtl/ttb_datapath.sv */
// Datapath of the travelled trail buffer: trail memory, distance pipeline,
// trail bookkeeping and result registers. Depends on ttb_pkg.
`timescale 1ns / 1ps

module ttb_datapath import ttb_pkg::*; #(
   parameter int TRAIL_DEPTH = TRAIL_DEPTH_DEFAULT,
   localparam int IDX_W = $clog2(TRAIL_DEPTH),
   localparam int CNT_W = $clog2(TRAIL_DEPTH + 1),
   localparam int SUM_W = IDX_W + 1
) (
   input  logic                      clock,
   input  logic                      reset,
   input  ctl_cmd_type               cmd,
   output dp_stat_type               stat,
   input  logic signed [COORD_W-1:0] req_pos_x,
   input  logic signed [COORD_W-1:0] req_pos_y,
   input  logic                      req_pose_valid,
   input  logic [COORD_W-1:0]        req_max_distance_mm,
   input  logic                      csr_write_en,
   input  logic                      csr_index,
   input  logic [COORD_W-1:0]        csr_wdata,
   output logic                      rsp_strobe,
   output logic [1:0]                rsp_status,
   output logic signed [COORD_W-1:0] rsp_point_x,
   output logic signed [COORD_W-1:0] rsp_point_y,
   output logic [CNT_W-1:0]          rsp_point_count,
   output logic                      rsp_last
);

   function automatic logic [IDX_W-1:0] slot_of(input logic [IDX_W-1:0] base,
                                                input logic [CNT_W-1:0] ofs);
      logic [SUM_W-1:0] sum;
      sum = SUM_W'(base) + SUM_W'(ofs);
      if (sum >= SUM_W'(TRAIL_DEPTH)) begin
         sum = sum - SUM_W'(TRAIL_DEPTH);
      end
      return sum[IDX_W-1:0];
   endfunction

   logic signed [COORD_W-1:0] px_ff, py_ff;
   logic                      valid_ff;
   logic [COORD_W-1:0]        maxd_ff;
   logic [COORD_W-1:0]        res_ff, rad_ff;

   logic [CNT_W-1:0]          len_ff, cnt_ff, best_ff, drop_ff;
   logic [IDX_W-1:0]          oldest_ff;
   logic [DIST_W-1:0]         res2_ff, rad2_ff, max2_ff, d2last_ff, bestd_ff;
   logic                      stop_ff;

   logic [2*COORD_W-1:0]      mem [TRAIL_DEPTH];
   logic [2*COORD_W-1:0]      rd_word_ff;

   logic                      v1_ff, v2_ff, v3_ff, v4_ff;
   kind_type                  k1_ff, k2_ff, k3_ff, k4_ff;
   logic [CNT_W-1:0]          i1_ff;
   logic [COORD_W-1:0]        a_ff, b_ff;
   logic [SQ_W-1:0]           pa_ff, pb_ff;
   logic [DIST_W-1:0]         dist_ff;

   logic                      strobe_ff, last_ff;
   status_type                status_ff;
   logic signed [COORD_W-1:0] ox_ff, oy_ff;
   logic [CNT_W-1:0]          ocnt_ff;

   logic [CNT_W-1:0]          iss_idx;
   logic [IDX_W-1:0]          rd_addr, wr_addr;
   logic                      wr_en, len_full, app_ok, trunc_ok;
   logic signed [COORD_W:0]   dx, dy;
   logic [COORD_W-1:0]        adx, ady, a_in, b_in;
   logic signed [COORD_W-1:0] rx, ry;

   assign iss_idx  = (cmd.iss_kind == KIND_LAST) ? len_ff - CNT_W'(1) : cnt_ff;
   assign rd_addr  = slot_of(oldest_ff, iss_idx);
   assign len_full = (len_ff == CNT_W'(TRAIL_DEPTH));
   assign app_ok   = (len_ff == '0) || (d2last_ff >= res2_ff);
   assign trunc_ok = ((best_ff + CNT_W'(1)) < len_ff);
   assign wr_en    = cmd.restart || (cmd.append && app_ok);
   assign wr_addr  = cmd.restart ? '0 :
                     (len_full ? oldest_ff : slot_of(oldest_ff, len_ff));

   // Request and configuration registers
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         px_ff    <= req_pos_x;
         py_ff    <= req_pos_y;
         valid_ff <= req_pose_valid;
         maxd_ff  <= req_max_distance_mm;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         res_ff <= COORD_W'(100);
         rad_ff <= '0;
      end else if (csr_write_en) begin
         if (csr_index == CSR_RESOLUTION) begin
            res_ff <= csr_wdata;
         end else begin
            rad_ff <= csr_wdata;
         end
      end
   end

   // Trail memory
   always_ff @(posedge clock) begin
      rd_word_ff <= mem[rd_addr];
      if (wr_en) begin
         mem[wr_addr] <= {px_ff, py_ff};
      end
   end

   // Distance pipeline: read, difference, square, sum
   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
      end else begin
         v1_ff <= cmd.iss_valid;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
         v4_ff <= v3_ff;
      end
   end

   assign rx  = rd_word_ff[2*COORD_W-1:COORD_W];
   assign ry  = rd_word_ff[COORD_W-1:0];
   assign dx  = {px_ff[COORD_W-1], px_ff} - {rx[COORD_W-1], rx};
   assign dy  = {py_ff[COORD_W-1], py_ff} - {ry[COORD_W-1], ry};
   assign adx = dx[COORD_W] ? COORD_W'(-dx) : dx[COORD_W-1:0];
   assign ady = dy[COORD_W] ? COORD_W'(-dy) : dy[COORD_W-1:0];

   always_comb begin
      case (k1_ff)
         KIND_RES: begin
            a_in = res_ff;
            b_in = '0;
         end
         KIND_RAD: begin
            a_in = rad_ff;
            b_in = '0;
         end
         KIND_MAX: begin
            a_in = maxd_ff;
            b_in = '0;
         end
         default: begin
            a_in = adx;
            b_in = ady;
         end
      endcase
   end

   logic [CNT_W-1:0] i2_ff, i3_ff, i4_ff;

   always_ff @(posedge clock) begin
      k1_ff   <= cmd.iss_kind;
      i1_ff   <= iss_idx;
      k2_ff   <= k1_ff;
      i2_ff   <= i1_ff;
      a_ff    <= a_in;
      b_ff    <= b_in;
      k3_ff   <= k2_ff;
      i3_ff   <= i2_ff;
      pa_ff   <= SQ_W'(a_ff) * SQ_W'(a_ff);
      pb_ff   <= SQ_W'(b_ff) * SQ_W'(b_ff);
      k4_ff   <= k3_ff;
      i4_ff   <= i3_ff;
      dist_ff <= DIST_W'(pa_ff) + DIST_W'(pb_ff);
   end

   // Capture finished distances by kind
   always_ff @(posedge clock) begin
      if (v4_ff && (k4_ff == KIND_RES)) res2_ff <= dist_ff;
      if (v4_ff && (k4_ff == KIND_RAD)) rad2_ff <= dist_ff;
      if (v4_ff && (k4_ff == KIND_MAX)) max2_ff <= dist_ff;
      if (v4_ff && (k4_ff == KIND_LAST)) begin
         d2last_ff <= dist_ff;
      end else if (cmd.truncate && trunc_ok) begin
         d2last_ff <= bestd_ff;
      end
      if (cmd.scan_init) begin
         best_ff  <= len_ff - CNT_W'(1);
         bestd_ff <= d2last_ff;
      end else if (v4_ff && (k4_ff == KIND_SCAN) && (dist_ff < bestd_ff)) begin
         best_ff  <= i4_ff;
         bestd_ff <= dist_ff;
      end
   end

   // Trail bookkeeping
   always_ff @(posedge clock) begin
      if (reset) begin
         len_ff    <= '0;
         oldest_ff <= '0;
         cnt_ff    <= '0;
         stop_ff   <= 1'b0;
         drop_ff   <= '0;
      end else begin
         if (cmd.restart) begin
            len_ff    <= CNT_W'(1);
            oldest_ff <= '0;
         end else if (cmd.truncate && trunc_ok) begin
            len_ff <= best_ff + CNT_W'(1);
         end else if (cmd.append && app_ok) begin
            if (len_full) begin
               oldest_ff <= slot_of(oldest_ff, CNT_W'(1));
            end else begin
               len_ff <= len_ff + CNT_W'(1);
            end
         end else if (cmd.prune_apply) begin
            oldest_ff <= slot_of(oldest_ff, drop_ff);
            len_ff    <= len_ff - drop_ff;
         end

         if (cmd.cnt_clear || cmd.prune_init) begin
            cnt_ff <= '0;
         end else if (cmd.cnt_inc) begin
            cnt_ff <= cnt_ff + CNT_W'(1);
         end

         if (cmd.prune_init) begin
            stop_ff <= 1'b0;
            drop_ff <= '0;
         end else if (v4_ff && (k4_ff == KIND_PRUNE) && !stop_ff) begin
            if (dist_ff <= max2_ff) begin
               stop_ff <= 1'b1;
            end else begin
               drop_ff <= drop_ff + CNT_W'(1);
            end
         end
      end
   end

   // Result registers
   always_ff @(posedge clock) begin
      if (reset) begin
         strobe_ff <= 1'b0;
      end else begin
         strobe_ff <= cmd.single || (v1_ff && (k1_ff == KIND_EMIT));
      end
   end

   always_ff @(posedge clock) begin
      ocnt_ff <= len_ff;
      if (cmd.single) begin
         status_ff <= cmd.single_status;
         ox_ff     <= '0;
         oy_ff     <= '0;
         last_ff   <= 1'b1;
      end else begin
         status_ff <= STAT_UPDATED;
         ox_ff     <= rx;
         oy_ff     <= ry;
         last_ff   <= (i1_ff == len_ff - CNT_W'(1));
      end
   end

   assign rsp_strobe      = strobe_ff;
   assign rsp_status      = status_ff;
   assign rsp_point_x     = ox_ff;
   assign rsp_point_y     = oy_ff;
   assign rsp_point_count = ocnt_ff;
   assign rsp_last        = last_ff;

   assign stat.pose_valid   = valid_ff;
   assign stat.len_zero     = (len_ff == '0);
   assign stat.len_ge2      = (len_ff >= CNT_W'(2));
   assign stat.maxd_zero    = (maxd_ff == '0);
   assign stat.below_res    = (d2last_ff < res2_ff);
   assign stat.within_rad   = (rad_ff != '0) && (d2last_ff <= rad2_ff);
   assign stat.cnt_scan_end = (cnt_ff == len_ff - CNT_W'(2));
   assign stat.cnt_last     = (cnt_ff == len_ff - CNT_W'(1));
   assign stat.pipe_busy    = v1_ff || v2_ff || v3_ff || v4_ff;

endmodule

/* rtl/ttb_ctrl.sv */
// Sequencer of the travelled trail buffer: steps one transaction through
// check, scan, truncate, append, prune and emit. Depends on ttb_pkg.
`timescale 1ns / 1ps

module ttb_ctrl import ttb_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  dp_stat_type stat,
   output ctl_cmd_type cmd
);

   state_type st_ff, st_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff <= ST_IDLE;
      end else begin
         st_ff <= st_in;
      end
   end

   always_comb begin
      st_in = st_ff;
      case (st_ff)
         ST_IDLE:     if (start) st_in = ST_CHECK;
         ST_CHECK:    st_in = stat.pose_valid ? ST_PRE_RES : ST_IDLE;
         ST_PRE_RES:  st_in = ST_PRE_RAD;
         ST_PRE_RAD:  st_in = ST_PRE_MAX;
         ST_PRE_MAX:  st_in = ST_PRE_LAST;
         ST_PRE_LAST: st_in = ST_PRE_WAIT;
         ST_PRE_WAIT: if (!stat.pipe_busy) st_in = ST_DECIDE;
         ST_DECIDE: begin
            if (stat.maxd_zero) begin
               st_in = (stat.within_rad && !stat.len_zero) ? ST_IDLE : ST_EMIT;
            end else if (!stat.len_zero && stat.below_res) begin
               st_in = ST_IDLE;
            end else if (stat.len_ge2) begin
               st_in = ST_SCAN;
            end else begin
               st_in = ST_APPEND;
            end
         end
         ST_SCAN:      if (stat.cnt_scan_end) st_in = ST_SCAN_WAIT;
         ST_SCAN_WAIT: if (!stat.pipe_busy) st_in = ST_TRUNC;
         ST_TRUNC:     st_in = ST_APPEND;
         ST_APPEND:    st_in = ST_PRUNE;
         ST_PRUNE: begin
            if (stat.len_zero || stat.cnt_last) st_in = ST_PRUNE_WAIT;
         end
         ST_PRUNE_WAIT:  if (!stat.pipe_busy) st_in = ST_PRUNE_APPLY;
         ST_PRUNE_APPLY: st_in = ST_EMIT;
         ST_EMIT: begin
            if (stat.len_zero) begin
               st_in = ST_IDLE;
            end else if (stat.cnt_last) begin
               st_in = ST_EMIT_WAIT;
            end
         end
         ST_EMIT_WAIT: if (!stat.pipe_busy) st_in = ST_IDLE;
         default:      st_in = ST_IDLE;
      endcase
   end

   always_comb begin
      cmd = '0;
      cmd.iss_kind = KIND_RES;
      cmd.single_status = STAT_UPDATED;
      case (st_ff)
         ST_IDLE: cmd.load = start;
         ST_CHECK: begin
            cmd.single        = !stat.pose_valid;
            cmd.single_status = STAT_NO_POSE;
         end
         ST_PRE_RES: begin
            cmd.iss_valid = 1'b1;
            cmd.iss_kind  = KIND_RES;
         end
         ST_PRE_RAD: begin
            cmd.iss_valid = 1'b1;
            cmd.iss_kind  = KIND_RAD;
         end
         ST_PRE_MAX: begin
            cmd.iss_valid = 1'b1;
            cmd.iss_kind  = KIND_MAX;
         end
         ST_PRE_LAST: begin
            cmd.iss_valid = !stat.len_zero;
            cmd.iss_kind  = KIND_LAST;
         end
         ST_DECIDE: begin
            cmd.single_status = STAT_UNCHANGED;
            if (stat.maxd_zero) begin
               if (stat.within_rad && !stat.len_zero) begin
                  cmd.single = 1'b1;
               end else begin
                  cmd.restart   = 1'b1;
                  cmd.cnt_clear = 1'b1;
               end
            end else if (!stat.len_zero && stat.below_res) begin
               cmd.single = 1'b1;
            end else if (stat.len_ge2) begin
               cmd.scan_init = 1'b1;
               cmd.cnt_clear = 1'b1;
            end
         end
         ST_SCAN: begin
            cmd.iss_valid = 1'b1;
            cmd.iss_kind  = KIND_SCAN;
            cmd.cnt_inc   = 1'b1;
         end
         ST_TRUNC: cmd.truncate = 1'b1;
         ST_APPEND: begin
            cmd.append     = 1'b1;
            cmd.prune_init = 1'b1;
         end
         ST_PRUNE: begin
            cmd.iss_valid = !stat.len_zero;
            cmd.iss_kind  = KIND_PRUNE;
            cmd.cnt_inc   = !stat.len_zero;
         end
         ST_PRUNE_APPLY: begin
            cmd.prune_apply = 1'b1;
            cmd.cnt_clear   = 1'b1;
         end
         ST_EMIT: begin
            cmd.single    = stat.len_zero;
            cmd.iss_valid = !stat.len_zero;
            cmd.iss_kind  = KIND_EMIT;
            cmd.cnt_inc   = !stat.len_zero;
         end
         default: ;
      endcase
   end

   assign busy = (st_ff != ST_IDLE);

endmodule

/* rtl/ttb_checker.sv */
// Port-level checks for the travelled trail buffer, bound to the top level.
// Depends on ttb_pkg and travelled_trail_buffer.
`timescale 1ns / 1ps

module ttb_checker import ttb_pkg::*; #(
   parameter int TRAIL_DEPTH = TRAIL_DEPTH_DEFAULT,
   localparam int CNT_W = $clog2(TRAIL_DEPTH + 1)
) (
   input logic             clock,
   input logic             reset,
   input logic             start,
   input logic             busy,
   input logic             rsp_strobe,
   input logic [1:0]       rsp_status,
   input logic [CNT_W-1:0] rsp_point_count,
   input logic             rsp_last
);

   // Reset leaves the block idle and silent
   a_reset_quiet: assert property (@(posedge clock)
      reset |=> (!busy && !rsp_strobe))
      else $error("busy or strobe after reset");

   // Accepted transaction raises busy
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("busy not raised after accept");

   // A trail streams without gaps and with a steady count
   a_stream: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && !rsp_last) |=> (rsp_strobe && $stable(rsp_point_count)))
      else $error("gap or count change inside a trail");

   // Non-update results are single
   a_single: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && (rsp_status != STAT_UPDATED)) |-> rsp_last)
      else $error("multi-point result with non-update status");

   // Two transactions' results never touch
   a_last_gap: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_last) |=> !rsp_strobe)
      else $error("result right after last");

endmodule

bind travelled_trail_buffer ttb_checker #(
   .TRAIL_DEPTH (TRAIL_DEPTH)
) u_ttb_checker (
   .clock           (clock),
   .reset           (reset),
   .start           (start),
   .busy            (busy),
   .rsp_strobe      (rsp_strobe),
   .rsp_status      (rsp_status),
   .rsp_point_count (rsp_point_count),
   .rsp_last        (rsp_last)
);
